FILE: hdl/ppp_pkg.sv
//------------------------------------------------------------------------------
// ppp_pkg
// Shared types, register map, reset values and fixed-point helpers for the
// pinhole point projection pipeline.
//------------------------------------------------------------------------------
package ppp_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int ROT_FRAC_BITS   = 14;
    localparam int DIV_STEPS       = 32;
    localparam int APB_ADDR_W      = 6;
    localparam int APB_DATA_W      = 64;
    localparam int SIZE_CMP_W      = 48;

    localparam logic [47:0] RST_ROT_ROW0        = 48'h0000_0000_4000;
    localparam logic [47:0] RST_ROT_ROW1        = 48'h0000_4000_0000;
    localparam logic [47:0] RST_ROT_ROW2        = 48'h4000_0000_0000;
    localparam logic [63:0] RST_TRANS_XY        = 64'h0;
    localparam logic [31:0] RST_TRANS_Z         = 32'h0;
    localparam logic [63:0] RST_FOCAL_LENGTHS   = 64'h0001_0000_0001_0000;
    localparam logic [63:0] RST_PRINCIPAL_POINT = 64'h0;
    localparam logic [31:0] RST_IMAGE_SIZE      = 32'h01E0_0500;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_ROT_ROW0,
        REG_ROT_ROW1,
        REG_ROT_ROW2,
        REG_TRANS_XY,
        REG_TRANS_Z,
        REG_FOCAL_LENGTHS,
        REG_PRINCIPAL_POINT,
        REG_IMAGE_SIZE
    } t_reg_idx;

    typedef struct packed {
        logic [47:0] rot_row0;
        logic [47:0] rot_row1;
        logic [47:0] rot_row2;
        logic [63:0] trans_xy;
        logic [31:0] trans_z;
        logic [63:0] focal_lengths;
        logic [63:0] principal_point;
        logic [31:0] image_size;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [31:0] image_u;
        logic signed [31:0] image_v;
        logic signed [31:0] depth;
        logic               in_front;
        logic               visible;
        logic               zero_depth;
    } t_result;

    // clamp to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        if (x[39:31] == 9'h000 || x[39:31] == 9'h1FF) begin
            return x[31:0];
        end
        return x[39] ? SAT_MIN : SAT_MAX;
    endfunction

endpackage

FILE: hdl/ppp_cfg_regs.sv
//------------------------------------------------------------------------------
// ppp_cfg_regs
// APB register file holding camera pose, intrinsics and image size.
//------------------------------------------------------------------------------
module ppp_cfg_regs import ppp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:3]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_row0        <= RST_ROT_ROW0;
            r_cfg.rot_row1        <= RST_ROT_ROW1;
            r_cfg.rot_row2        <= RST_ROT_ROW2;
            r_cfg.trans_xy        <= RST_TRANS_XY;
            r_cfg.trans_z         <= RST_TRANS_Z;
            r_cfg.focal_lengths   <= RST_FOCAL_LENGTHS;
            r_cfg.principal_point <= RST_PRINCIPAL_POINT;
            r_cfg.image_size      <= RST_IMAGE_SIZE;
        end else if (w_wr) begin
            case (w_idx)
                REG_ROT_ROW0:        r_cfg.rot_row0        <= pwdata[47:0];
                REG_ROT_ROW1:        r_cfg.rot_row1        <= pwdata[47:0];
                REG_ROT_ROW2:        r_cfg.rot_row2        <= pwdata[47:0];
                REG_TRANS_XY:        r_cfg.trans_xy        <= pwdata;
                REG_TRANS_Z:         r_cfg.trans_z         <= pwdata[31:0];
                REG_FOCAL_LENGTHS:   r_cfg.focal_lengths   <= pwdata;
                REG_PRINCIPAL_POINT: r_cfg.principal_point <= pwdata;
                REG_IMAGE_SIZE:      r_cfg.image_size      <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ROT_ROW0:        prdata = {16'h0, r_cfg.rot_row0};
            REG_ROT_ROW1:        prdata = {16'h0, r_cfg.rot_row1};
            REG_ROT_ROW2:        prdata = {16'h0, r_cfg.rot_row2};
            REG_TRANS_XY:        prdata = r_cfg.trans_xy;
            REG_TRANS_Z:         prdata = {32'h0, r_cfg.trans_z};
            REG_FOCAL_LENGTHS:   prdata = r_cfg.focal_lengths;
            REG_PRINCIPAL_POINT: prdata = r_cfg.principal_point;
            REG_IMAGE_SIZE:      prdata = {32'h0, r_cfg.image_size};
            default:             prdata = '0;
        endcase
    end

endmodule

FILE: hdl/ppp_transform.sv
//------------------------------------------------------------------------------
// ppp_transform
// Three-stage world-to-camera transform: products, rounded row sums,
// shift plus translation with saturation.
//------------------------------------------------------------------------------
module ppp_transform import ppp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_point             i_point,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output logic signed [31:0] o_cam_x,
    output logic signed [31:0] o_cam_y,
    output logic signed [31:0] o_cam_z
);

    localparam logic signed [49:0] ROUND_ADD = 50'sd1 <<< (ROT_FRAC_BITS - 1);

    logic        [47:0] w_row [3];
    logic signed [31:0] w_pt  [3];
    logic signed [31:0] w_t   [3];

    logic               r_v1, r_v2, r_v3;
    logic signed [47:0] r_prod [3][3];
    logic signed [49:0] r_acc  [3];
    logic signed [31:0] r_cam  [3];

    assign w_row[0] = i_cfg.rot_row0;
    assign w_row[1] = i_cfg.rot_row1;
    assign w_row[2] = i_cfg.rot_row2;
    assign w_pt[0]  = i_point.point_x;
    assign w_pt[1]  = i_point.point_y;
    assign w_pt[2]  = i_point.point_z;
    assign w_t[0]   = $signed(i_cfg.trans_xy[31:0]);
    assign w_t[1]   = $signed(i_cfg.trans_xy[63:32]);
    assign w_t[2]   = $signed(i_cfg.trans_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= $signed(w_row[i][16*j +: 16]) * w_pt[j];
                end
                r_acc[i] <= 50'(r_prod[i][0]) + 50'(r_prod[i][1])
                          + 50'(r_prod[i][2]) + ROUND_ADD;
                r_cam[i] <= sat32(40'(r_acc[i] >>> ROT_FRAC_BITS) + 40'(w_t[i]));
            end
        end
    end

    assign o_valid = r_v3;
    assign o_cam_x = r_cam[0];
    assign o_cam_y = r_cam[1];
    assign o_cam_z = r_cam[2];

endmodule

FILE: hdl/ppp_divider.sv
//------------------------------------------------------------------------------
// ppp_divider
// Two-lane pipelined signed divider, one quotient bit per stage, with a
// shared divisor. Quotients truncate toward zero and saturate to 32 bits;
// a zero divisor saturates by the sign of the numerator.
//------------------------------------------------------------------------------
module ppp_divider import ppp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [63:0] i_num_x,
    input  logic signed [63:0] i_num_y,
    input  logic signed [31:0] i_den,
    output logic               o_valid,
    output logic signed [31:0] o_quo_x,
    output logic signed [31:0] o_quo_y,
    output logic signed [31:0] o_den
);

    function automatic logic [63:0] div_step(input logic [63:0] w, input logic [31:0] d);
        logic [32:0] t;
        t = w[63:31] - {1'b0, d};
        if (!t[32]) begin
            return {t[31:0], w[30:0], 1'b1};
        end
        return {w[62:0], 1'b0};
    endfunction

    function automatic logic signed [31:0] finish(
        input logic [31:0] q,
        input logic        neg,
        input logic        ovf
    );
        if (ovf) begin
            return neg ? SAT_MIN : SAT_MAX;
        end
        if (neg) begin
            return (q > 32'h8000_0000) ? SAT_MIN : $signed(-q);
        end
        return q[31] ? SAT_MAX : $signed(q);
    endfunction

    logic signed [63:0] w_num [2];

    // magnitude stage
    logic               r_p1_v;
    logic        [63:0] r_p1_mag  [2];
    logic               r_p1_nneg [2];
    logic        [31:0] r_p1_dmag;
    logic               r_p1_dneg;
    logic signed [31:0] r_p1_den;

    // overflow check and bit-serial stages
    logic               r_v   [DIV_STEPS+1];
    logic        [63:0] r_w   [2][DIV_STEPS+1];
    logic               r_neg [2][DIV_STEPS+1];
    logic               r_ovf [2][DIV_STEPS+1];
    logic        [31:0] r_d   [DIV_STEPS+1];
    logic signed [31:0] r_den [DIV_STEPS+1];

    // result stage
    logic               r_f_v;
    logic signed [31:0] r_f_q [2];
    logic signed [31:0] r_f_den;

    assign w_num[0] = i_num_x;
    assign w_num[1] = i_num_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_f_v <= 1'b0;
        end else if (i_en) begin
            r_p1_v <= i_valid;
            r_v[0] <= r_p1_v;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_f_v <= r_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_p1_mag[l]  <= w_num[l][63] ? 64'(-w_num[l]) : 64'(w_num[l]);
                r_p1_nneg[l] <= w_num[l][63];

                r_ovf[l][0] <= (r_p1_dmag == 32'h0) || (r_p1_mag[l][63:32] >= r_p1_dmag);
                r_neg[l][0] <= (r_p1_dmag == 32'h0) ? r_p1_nneg[l]
                                                   : (r_p1_nneg[l] ^ r_p1_dneg);
                r_w[l][0]   <= r_p1_mag[l];

                for (int k = 0; k < DIV_STEPS; k++) begin
                    r_w[l][k+1]   <= div_step(r_w[l][k], r_d[k]);
                    r_neg[l][k+1] <= r_neg[l][k];
                    r_ovf[l][k+1] <= r_ovf[l][k];
                end

                r_f_q[l] <= finish(r_w[l][DIV_STEPS][31:0], r_neg[l][DIV_STEPS],
                                   r_ovf[l][DIV_STEPS]);
            end

            r_p1_dmag <= i_den[31] ? 32'(-i_den) : 32'(i_den);
            r_p1_dneg <= i_den[31];
            r_p1_den  <= i_den;

            r_d[0]   <= r_p1_dmag;
            r_den[0] <= r_p1_den;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_d[k+1]   <= r_d[k];
                r_den[k+1] <= r_den[k];
            end

            r_f_den <= r_den[DIV_STEPS];
        end
    end

    assign o_valid = r_f_v;
    assign o_quo_x = r_f_q[0];
    assign o_quo_y = r_f_q[1];
    assign o_den   = r_f_den;

endmodule

FILE: hdl/pinhole_point_projection.sv
//------------------------------------------------------------------------------
// pinhole_point_projection
// Projects world points through a configured pose and pinhole intrinsics
// to image coordinates with depth, front and visibility flags.
//------------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; the 32-stage bit-serial divider sets depth.
// A stalled output stalls the whole pipeline once the stage behind it is full.
// Reset clears all valid bits and loads the identity pose, unit focal lengths,
// zero principal point and a 1280 x 480 image.
//------------------------------------------------------------------------------
module pinhole_point_projection import ppp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_point                i_point,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_result               o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg               w_cfg;
    logic               w_en;

    logic               w_t_v;
    logic signed [31:0] w_cam_x, w_cam_y, w_cam_z;

    logic               r_m_v;
    logic signed [63:0] r_num_x, r_num_y;
    logic signed [31:0] r_m_z;

    logic               w_d_v;
    logic signed [31:0] w_q_x, w_q_y, w_d_den;

    logic               r_e_v;
    logic signed [31:0] r_e_u, r_e_v_coord, r_e_z;
    logic               r_e_front, r_e_zero;

    logic               r_out_v;
    t_result            r_out;
    logic               w_out_load;

    logic [SIZE_CMP_W-1:0] w_width_lim, w_height_lim;
    logic                  w_u_in, w_v_in;

    ppp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // advance unless the last stage holds an item the output cannot take
    assign w_out_load = ~r_out_v | i_ready;
    assign w_en       = ~r_e_v | w_out_load;
    assign o_ready    = w_en;

    ppp_transform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_point (i_point),
        .i_cfg   (w_cfg),
        .o_valid (w_t_v),
        .o_cam_x (w_cam_x),
        .o_cam_y (w_cam_y),
        .o_cam_z (w_cam_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (w_en) begin
            r_m_v <= w_t_v;
            r_e_v <= w_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num_x <= $signed(w_cfg.focal_lengths[31:0]) * w_cam_x;
            r_num_y <= $signed(w_cfg.focal_lengths[63:32]) * w_cam_y;
            r_m_z   <= w_cam_z;
        end
    end

    ppp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m_v),
        .i_num_x (r_num_x),
        .i_num_y (r_num_y),
        .i_den   (r_m_z),
        .o_valid (w_d_v),
        .o_quo_x (w_q_x),
        .o_quo_y (w_q_y),
        .o_den   (w_d_den)
    );

    // add principal point, except where zero depth already saturated
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_u       <= (w_d_den == 32'sh0) ? w_q_x
                         : sat32(40'(w_q_x) + 40'($signed(w_cfg.principal_point[31:0])));
            r_e_v_coord <= (w_d_den == 32'sh0) ? w_q_y
                         : sat32(40'(w_q_y) + 40'($signed(w_cfg.principal_point[63:32])));
            r_e_z       <= w_d_den;
            r_e_front   <= ~w_d_den[31] && (w_d_den != 32'sh0);
            r_e_zero    <= (w_d_den == 32'sh0);
        end
    end

    assign w_width_lim  = SIZE_CMP_W'(w_cfg.image_size[15:0])  << COORD_FRAC_BITS;
    assign w_height_lim = SIZE_CMP_W'(w_cfg.image_size[31:16]) << COORD_FRAC_BITS;
    assign w_u_in = ~r_e_u[31]
                  && (SIZE_CMP_W'($unsigned(r_e_u)) < w_width_lim);
    assign w_v_in = ~r_e_v_coord[31]
                  && (SIZE_CMP_W'($unsigned(r_e_v_coord)) < w_height_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.image_u    <= r_e_u;
            r_out.image_v    <= r_e_v_coord;
            r_out.depth      <= r_e_z;
            r_out.in_front   <= r_e_front;
            r_out.visible    <= r_e_front & w_u_in & w_v_in;
            r_out.zero_depth <= r_e_zero;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

FILE: sim/projection_checker.sv
//------------------------------------------------------------------------------
// projection_checker
// Watches the point and result channels and the register port of the pinhole
// point projection block. Keeps its own copy of the pose and intrinsics,
// predicts each projected result from the accepted point and checks every
// result, field by field, in order against the oldest prediction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module projection_checker import ppp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_ready,
    input  t_point                i_point,
    input  logic                  o_valid,
    input  logic                  i_ready,
    input  t_result               o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    t_cfg    cam_cfg;
    t_result projected_q[$];
    t_result want;
    int      fail_cnt = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint clamp_q(input longint x);
        if (x > Q_MAX) return Q_MAX;
        if (x < Q_MIN) return Q_MIN;
        return x;
    endfunction

    // rotate one row, round at the Q2.14 point, add translation
    function automatic longint camera_axis(input logic [47:0] row, input t_point p,
                                           input logic [31:0] t);
        longint r0, r1, r2, px, py, pz, tt, acc;
        r0 = longint'($signed(row[15:0]));
        r1 = longint'($signed(row[31:16]));
        r2 = longint'($signed(row[47:32]));
        px = longint'($signed(p.point_x));
        py = longint'($signed(p.point_y));
        pz = longint'($signed(p.point_z));
        tt = longint'($signed(t));
        acc = r0 * px + r1 * py + r2 * pz;
        acc = (acc + (64'sd1 <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
        return clamp_q(acc + tt);
    endfunction

    function automatic longint image_axis(input logic [31:0] f_w, input longint c,
                                          input longint z, input logic [31:0] off_w);
        longint f, off, num;
        f   = longint'($signed(f_w));
        off = longint'($signed(off_w));
        num = f * c;
        if (z == 0) return (num >= 0) ? Q_MAX : Q_MIN;
        return clamp_q(clamp_q(num / z) + off);
    endfunction

    function automatic t_result project_point(input t_cfg c, input t_point p);
        t_result r;
        longint  cam_x, cam_y, cam_z, u, v, w, h;
        cam_x = camera_axis(c.rot_row0, p, c.trans_xy[31:0]);
        cam_y = camera_axis(c.rot_row1, p, c.trans_xy[63:32]);
        cam_z = camera_axis(c.rot_row2, p, c.trans_z);
        u = image_axis(c.focal_lengths[31:0], cam_x, cam_z, c.principal_point[31:0]);
        v = image_axis(c.focal_lengths[63:32], cam_y, cam_z, c.principal_point[63:32]);
        w = longint'(c.image_size[15:0]);
        w = w <<< COORD_FRAC_BITS;
        h = longint'(c.image_size[31:16]);
        h = h <<< COORD_FRAC_BITS;
        r.image_u    = u[31:0];
        r.image_v    = v[31:0];
        r.depth      = cam_z[31:0];
        r.in_front   = cam_z > 0;
        r.zero_depth = cam_z == 0;
        r.visible    = (cam_z > 0) && (u >= 0) && (u < w) && (v >= 0) && (v < h);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("ERROR at %0t ns: %s got %h, expected %h", $time, what, got, exp_val);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cam_cfg = {RST_ROT_ROW0, RST_ROT_ROW1, RST_ROT_ROW2, RST_TRANS_XY, RST_TRANS_Z,
                       RST_FOCAL_LENGTHS, RST_PRINCIPAL_POINT, RST_IMAGE_SIZE};
            projected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:3])
                    REG_ROT_ROW0:        cam_cfg.rot_row0        = pwdata[47:0];
                    REG_ROT_ROW1:        cam_cfg.rot_row1        = pwdata[47:0];
                    REG_ROT_ROW2:        cam_cfg.rot_row2        = pwdata[47:0];
                    REG_TRANS_XY:        cam_cfg.trans_xy        = pwdata;
                    REG_TRANS_Z:         cam_cfg.trans_z         = pwdata[31:0];
                    REG_FOCAL_LENGTHS:   cam_cfg.focal_lengths   = pwdata;
                    REG_PRINCIPAL_POINT: cam_cfg.principal_point = pwdata;
                    REG_IMAGE_SIZE:      cam_cfg.image_size      = pwdata[31:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                projected_q.push_back(project_point(cam_cfg, i_point));
            end
            if (o_valid && i_ready) begin
                if (projected_q.size() == 0) begin
                    report_mismatch("result with no item pending, image_u", o_result.image_u,
                                    32'h0);
                end else begin
                    want = projected_q.pop_front();
                    if (o_result.image_u !== want.image_u)
                        report_mismatch("image_u", o_result.image_u, want.image_u);
                    if (o_result.image_v !== want.image_v)
                        report_mismatch("image_v", o_result.image_v, want.image_v);
                    if (o_result.depth !== want.depth)
                        report_mismatch("depth", o_result.depth, want.depth);
                    if (o_result.in_front !== want.in_front)
                        report_mismatch("in_front", 32'(o_result.in_front),
                                        32'(want.in_front));
                    if (o_result.visible !== want.visible)
                        report_mismatch("visible", 32'(o_result.visible),
                                        32'(want.visible));
                    if (o_result.zero_depth !== want.zero_depth)
                        report_mismatch("zero_depth", 32'(o_result.zero_depth),
                                        32'(want.zero_depth));
                end
            end
        end
        o_pending    <= projected_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

FILE: sim/testbench.sv
//------------------------------------------------------------------------------
// testbench
// Drives world points and register writes into the pinhole point projection
// block: directed corner points first, then phases of random camera poses and
// extreme register settings with random points, random idling on both sides,
// a long output stall and a full drain mid-phase. Checking is left to the
// projection checker; this module gives the verdict.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ppp_pkg::*;

    localparam int PIPE_LATENCY   = 41;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT    = 20000;
    localparam logic [31:0] ONE   = 32'h0001_0000;
    localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN = 32'h8000_0000;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    t_point                i_point = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_result               o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   n_errors;
    int   n_pending;
    t_cfg cur_cfg;
    bit   tx_idle_en  = 1'b0;
    bit   rx_idle_en  = 1'b0;
    bit   rx_hold_req = 1'b0;
    bit   drained;

    always #6 i_clk = ~i_clk;

    pinhole_point_projection u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_point  (i_point),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    projection_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_point      (i_point),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (o_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (n_errors),
        .o_pending    (n_pending)
    );

    function automatic t_point mk_point(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z);
        t_point p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        return p;
    endfunction

    function automatic logic [31:0] special_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'h1;
            2:       return 32'hFFFF_FFFF;
            3:       return ONE;
            4:       return -ONE;
            5:       return W_MAX;
            6:       return W_MIN;
            default: return 32'h7FFF_0000;
        endcase
    endfunction

    function automatic logic [15:0] rot_entry(input bit on_diag);
        int e;
        if (on_diag) begin
            e = 16384 - $urandom_range(0, 2048);
            if ($urandom_range(0, 3) == 0) e = -e;
        end else begin
            e = $urandom_range(0, 4096) - 2048;
        end
        return e[15:0];
    endfunction

    function automatic t_cfg make_cfg(input int kind);
        t_cfg c;
        int   w, h, fx, fy, tx, ty, tz;
        case (kind)
            0: c = '1;
            1: c = '0;
            2: begin
                c.rot_row0        = {3{16'h7FFF}};
                c.rot_row1        = {3{16'h7FFF}};
                c.rot_row2        = {3{16'h7FFF}};
                c.trans_xy        = {2{W_MAX}};
                c.trans_z         = W_MAX;
                c.focal_lengths   = {2{W_MAX}};
                c.principal_point = {2{W_MAX}};
                c.image_size      = 32'hFFFF_FFFF;
            end
            3: begin
                c.rot_row0        = {3{16'h8000}};
                c.rot_row1        = {3{16'h8000}};
                c.rot_row2        = {3{16'h8000}};
                c.trans_xy        = {2{W_MIN}};
                c.trans_z         = W_MIN;
                c.focal_lengths   = {2{W_MIN}};
                c.principal_point = {2{W_MIN}};
                c.image_size      = 32'h0001_0001;
            end
            4: begin
                c.rot_row0        = 48'({$urandom, $urandom});
                c.rot_row1        = 48'({$urandom, $urandom});
                c.rot_row2        = 48'({$urandom, $urandom});
                c.trans_xy        = {$urandom, $urandom};
                c.trans_z         = $urandom;
                c.focal_lengths   = {$urandom, $urandom};
                c.principal_point = {$urandom, $urandom};
                c.image_size      = $urandom;
            end
            default: begin
                if ($urandom_range(0, 2) == 0) begin
                    c.rot_row0 = RST_ROT_ROW0;
                    c.rot_row1 = RST_ROT_ROW1;
                    c.rot_row2 = RST_ROT_ROW2;
                end else begin
                    c.rot_row0 = {rot_entry(0), rot_entry(0), rot_entry(1)};
                    c.rot_row1 = {rot_entry(0), rot_entry(1), rot_entry(0)};
                    c.rot_row2 = {rot_entry(1), rot_entry(0), rot_entry(0)};
                end
                w  = $urandom_range(16, 2048);
                h  = $urandom_range(16, 2048);
                fx = ($urandom_range(50, 1500) << 16) | $urandom_range(0, 16'hFFFF);
                fy = ($urandom_range(50, 1500) << 16) | $urandom_range(0, 16'hFFFF);
                tx = $urandom_range(0, 100 << 16) - (50 << 16);
                ty = $urandom_range(0, 100 << 16) - (50 << 16);
                tz = $urandom_range(0, 40 << 16) - (10 << 16);
                c.trans_xy        = {ty[31:0], tx[31:0]};
                c.trans_z         = tz[31:0];
                c.focal_lengths   = {fy[31:0], fx[31:0]};
                c.principal_point = {h[31:0] << 15, w[31:0] << 15};
                c.image_size      = {h[15:0], w[15:0]};
            end
        endcase
        return c;
    endfunction

    function automatic t_point pick_point();
        t_point p;
        int     zz, span;
        zz   = $urandom_range(32'h0001_0000, 32'h00C8_0000);
        span = $urandom_range(0, 1) ? zz : zz / 2;
        p.point_x = $urandom_range(0, 2 * span) - span;
        p.point_y = $urandom_range(0, 2 * span) - span;
        p.point_z = zz;
        case ($urandom_range(0, 9))
            6: p = {$urandom, $urandom, $urandom};
            7: p = mk_point(special_word(), special_word(), special_word());
            // cancel the translation so an identity depth row lands on zero
            8: p.point_z = -cur_cfg.trans_z;
            9: begin
                p.point_x = $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
                p.point_y = $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
                p.point_z = $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic cfg_write(input t_reg_idx idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg c, input logic [15:0] pad);
        cur_cfg = c;
        cfg_write(REG_ROT_ROW0, {pad, c.rot_row0});
        cfg_write(REG_ROT_ROW1, {pad, c.rot_row1});
        cfg_write(REG_ROT_ROW2, {pad, c.rot_row2});
        cfg_write(REG_TRANS_XY, c.trans_xy);
        cfg_write(REG_TRANS_Z, {pad, pad, c.trans_z});
        cfg_write(REG_FOCAL_LENGTHS, c.focal_lengths);
        cfg_write(REG_PRINCIPAL_POINT, c.principal_point);
        cfg_write(REG_IMAGE_SIZE, {pad, pad, c.image_size});
    endtask

    task automatic send_point(input t_point p);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point <= p;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // drop valid, wait for every pending result, then let the pipeline settle
    task automatic wait_for_results();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (n_pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        drained = (n_pending == 0);
        repeat (PIPE_LATENCY + 20) @(posedge i_clk);
    endtask

    initial begin
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #(12 * 500_000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_cfg edge_cfg;
        int   n_items;
        cur_cfg = {RST_ROT_ROW0, RST_ROT_ROW1, RST_ROT_ROW2, RST_TRANS_XY, RST_TRANS_Z,
                   RST_FOCAL_LENGTHS, RST_PRINCIPAL_POINT, RST_IMAGE_SIZE};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // identity pose, unit focal lengths, 1280 x 480
        send_point(mk_point(32'h0, 32'h0, 32'h0));
        send_point(mk_point(32'hFFFF_FFFF, 32'h1, 32'h0));
        send_point(mk_point(32'h0, 32'h0, ONE));
        send_point(mk_point(1280 * ONE - 1, 480 * ONE - 1, ONE));
        send_point(mk_point(1280 * ONE, 480 * ONE - 1, ONE));
        send_point(mk_point(32'hFFFF_FFFF, 32'h0, ONE));
        send_point(mk_point(ONE, ONE, -ONE));
        send_point(mk_point(W_MAX, W_MIN, 32'h1));
        send_point(mk_point(W_MIN, W_MAX, 32'h1));
        send_point(mk_point(W_MAX, W_MAX, W_MAX));
        send_point(mk_point(W_MIN, W_MIN, W_MIN));
        send_point(mk_point(32'h0, 32'h0, W_MIN));
        send_point(mk_point(5 * ONE, 3 * ONE, 2 * ONE));
        send_point(mk_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F));
        wait_for_results();

        // translation at the limits: camera coordinates clamp
        edge_cfg = cur_cfg;
        edge_cfg.trans_xy        = {W_MIN, W_MAX};
        edge_cfg.trans_z         = W_MAX;
        edge_cfg.focal_lengths   = {-ONE, W_MAX};
        edge_cfg.principal_point = {W_MIN, W_MAX};
        edge_cfg.image_size      = 32'hFFFF_FFFF;
        load_config(edge_cfg, 16'h0000);
        send_point(mk_point(W_MAX, W_MIN, W_MAX));
        send_point(mk_point(W_MIN, W_MAX, W_MIN));
        send_point(mk_point(32'h0, 32'h0, 32'h8000_0001));
        send_point(mk_point(ONE, ONE, 32'h0));
        send_point(mk_point(W_MIN, W_MIN, 32'h1));
        wait_for_results();

        for (int ph = 0; ph < 12; ph++) begin
            load_config(make_cfg((ph < 5) ? ph : 5), (ph == 0) ? 16'hFFFF : 16'($urandom));
            n_items    = (ph < 5) ? 60 : 175;
            tx_idle_en = (ph % 3 != 2) && (ph != 7) && (ph != 11);
            rx_idle_en = (ph % 4 != 3) && (ph != 11);
            if (ph == 7) rx_hold_req = 1'b1;
            for (int i = 0; i < n_items; i++) begin
                send_point(pick_point());
                if (ph == 9 && i == 90) wait_for_results();
            end
            wait_for_results();
        end

        if (n_errors == 0 && drained && n_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
